FILE: design/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Operation codes carried in the func field.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One request item.
  typedef struct packed {
    logic               func;
    logic signed [31:0] item_value;
    logic        [15:0] item_priority;
  } in_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] out_value;
    logic        [15:0] out_priority;
    logic        [1:0]  status;
    logic        [4:0]  fill_count;
  } out_t;

  // Datapath operation selected by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY
  } op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic func;
    logic full;
    logic empty;
  } stat_t;

endpackage

`default_nettype wire

FILE: design/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output spq_pkg::cmd_t       cmd,
  input  wire spq_pkg::stat_t stat
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencing and command decode.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.func == FUNC_INSERT) begin
          cmd.op = stat.full ? OP_REFUSE_FULL : OP_INSERT;
        end else begin
          cmd.op = stat.empty ? OP_REFUSE_EMPTY : OP_REMOVE;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire spq_pkg::in_t   in_data,
  input  wire spq_pkg::cmd_t  cmd,
  output spq_pkg::stat_t      stat,
  output spq_pkg::out_t       out_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // Sorted cell row, head at index zero.
  logic signed [31:0]            val_r [DEPTH];
  logic signed [31:0]            val_nxt [DEPTH];
  logic [PRIORITY_BITS-1:0]      pri_r [DEPTH];
  logic [PRIORITY_BITS-1:0]      pri_nxt [DEPTH];
  logic [CW-1:0]                 count_r, count_nxt;
  in_t                           req_r;
  out_t                          out_r, out_nxt;

  logic [PRIORITY_BITS-1:0]      new_pri;
  logic [DEPTH-1:0]              le;
  logic [DEPTH-1:0]              take_new;

  assign new_pri = PRIORITY_BITS'(req_r.item_priority);

  // Per-cell compare: held and not behind the new entry.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CW'(i) < count_r) && (pri_r[i] <= new_pri);
    end
    take_new[0] = 1'b1;
    for (int i = 1; i < DEPTH; i++) begin
      take_new[i] = le[i-1];
    end
  end

  assign stat.func  = req_r.func;
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

  // Next cell contents, count and result.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
    end
    count_nxt = count_r;
    out_nxt   = out_r;
    case (cmd.op)
      OP_INSERT: begin
        // Cells ahead keep, the first cell behind takes the new entry,
        // the rest shift one place toward the tail.
        for (int i = 0; i < DEPTH; i++) begin
          if (!le[i]) begin
            if (take_new[i] || i == 0) begin
              val_nxt[i] = req_r.item_value;
              pri_nxt[i] = new_pri;
            end else begin
              val_nxt[i] = val_r[(i > 0) ? i - 1 : 0];
              pri_nxt[i] = pri_r[(i > 0) ? i - 1 : 0];
            end
          end
        end
        count_nxt              = count_r + CW'(1);
        out_nxt.out_value      = '0;
        out_nxt.out_priority   = '0;
        out_nxt.status         = ST_DONE;
        out_nxt.fill_count     = 5'(count_r + CW'(1));
      end
      OP_REMOVE: begin
        // Every cell but the last takes its tail-side neighbor.
        for (int i = 0; i < DEPTH - 1; i++) begin
          val_nxt[i] = val_r[i+1];
          pri_nxt[i] = pri_r[i+1];
        end
        count_nxt              = count_r - CW'(1);
        out_nxt.out_value      = val_r[0];
        out_nxt.out_priority   = 16'(pri_r[0]);
        out_nxt.status         = ST_DONE;
        out_nxt.fill_count     = 5'(count_r - CW'(1));
      end
      OP_REFUSE_FULL: begin
        out_nxt.out_value      = '0;
        out_nxt.out_priority   = '0;
        out_nxt.status         = ST_FULL;
        out_nxt.fill_count     = 5'(count_r);
      end
      OP_REFUSE_EMPTY: begin
        out_nxt.out_value      = '0;
        out_nxt.out_priority   = '0;
        out_nxt.status         = ST_EMPTY;
        out_nxt.fill_count     = 5'(count_r);
      end
      default: begin
      end
    endcase
  end

  // Entry count is the only state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Cells, request and result registers.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      val_r[i] <= val_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
    out_r <= out_nxt;
    if (cmd.load) begin
      req_r <= in_data;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

FILE: design/stable_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data   (spq_pkg::in_t)
// out      output     out_valid / out_ready  out_data  (spq_pkg::out_t)
//
// Each request passes the idle state (transfer in), the execute state (every
// cell compares and shifts in parallel) and the output state (result shown).
// A new request is taken once the previous result has been transferred out.
// Reset clears the entry count and sequencer state only; cells need no clearing.
// While out_ready is low the result holds and in_ready stays low.
module stable_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire spq_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output spq_pkg::out_t      out_data
);
  import spq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Sorted cell row and result register.
  spq_datapath #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: verif/stable_priority_queue_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int PRIO_BITS   = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int DEFAULT_IDLE_PCT = 28;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  in_t   in_data;
  logic  out_valid;
  logic  out_ready;
  out_t  out_data;

  // Shadow copy of the sorted queue contents, head at index 0.
  logic signed [31:0] held_vals [QUEUE_DEPTH];
  logic [15:0]        held_pris [QUEUE_DEPTH];
  int                 held_count;
  int                 peak_count;

  // Results predicted at each input transfer, oldest first.
  out_t pending_results [$];

  int idle_pct = DEFAULT_IDLE_PCT;
  int stall_pct = DEFAULT_IDLE_PCT;
  int hold_request = 0;
  int errors = 0;
  int results_seen = 0;
  int inserts_done = 0;
  int removes_done = 0;
  int full_refusals = 0;
  int empty_refusals = 0;
  int stuck_cycles = 0;

  stable_priority_queue #(
    .DEPTH         (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIO_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one request to the shadow queue and return the result it should produce.
  function automatic out_t apply_queue_op(input in_t req);
    out_t res;
    int   pos;
    res = '0;
    if (req.func == FUNC_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // New entry goes behind every entry of equal or lower priority number.
        pos = 0;
        while (pos < held_count && held_pris[pos] <= req.item_priority) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_vals[i] = held_vals[i - 1];
          held_pris[i] = held_pris[i - 1];
        end
        held_vals[pos] = req.item_value;
        held_pris[pos] = req.item_priority;
        held_count++;
        res.status = ST_DONE;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_value    = held_vals[0];
        res.out_priority = held_pris[0];
        for (int i = 1; i < held_count; i++) begin
          held_vals[i - 1] = held_vals[i];
          held_pris[i - 1] = held_pris[i];
        end
        held_count--;
        res.status = ST_DONE;
      end
    end
    res.fill_count = held_count[4:0];
    if (held_count > peak_count) peak_count = held_count;
    return res;
  endfunction

  // Priorities lean toward a few small numbers so that ties are common.
  function automatic logic [15:0] pick_priority();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 16'($urandom_range(0, 3));
    else if (roll < 50) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    else return 16'($urandom);
  endfunction

  function automatic in_t random_request(input logic func);
    in_t req;
    req.func          = func;
    req.item_value    = $urandom;
    req.item_priority = pick_priority();
    return req;
  endfunction

  // Offer one item and hold it until the transfer; valid is left high for the caller.
  task automatic send_item(input in_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_queue_op(item));
  endtask

  // Drop valid and wait until every predicted result has been transferred out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // Remove on an empty queue, with noise in the ignored fields.
    send_item(in_t'{FUNC_REMOVE, 32'sh7FFF_FFFF, 16'hFFFF});
    // Field extremes and a three-way tie at priority zero.
    send_item(in_t'{FUNC_INSERT, 32'sh7FFF_FFFF, 16'hFFFF});
    send_item(in_t'{FUNC_INSERT, 32'sh8000_0000, 16'h0000});
    send_item(in_t'{FUNC_INSERT, 32'sh0000_0000, 16'h8000});
    send_item(in_t'{FUNC_INSERT, -32'sd1,        16'h0000});
    send_item(in_t'{FUNC_INSERT, 32'sh5555_AAAA, 16'h0001});
    send_item(in_t'{FUNC_INSERT, 32'sd1,         16'h0000});
    send_item(in_t'{FUNC_INSERT, 32'shAAAA_5555, 16'hFFFF});
    repeat (8) send_item(in_t'{FUNC_REMOVE, 32'sh0000_0000, 16'h0000});
    send_item(in_t'{FUNC_REMOVE, 32'shFFFF_FFFF, 16'h5A5A});
    wait_for_results();
  endtask

  task automatic test_full_queue();
    while (held_count < QUEUE_DEPTH) send_item(random_request(FUNC_INSERT));
    repeat (3) send_item(random_request(FUNC_INSERT));
    repeat (QUEUE_DEPTH + 1) send_item(random_request(FUNC_REMOVE));
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_request = 300;
    repeat (20) send_item(random_request(($urandom_range(0, 99) < 60) ? FUNC_INSERT
                                                                      : FUNC_REMOVE));
    wait_for_results();
  endtask

  // Well-formed fill and drain runs mixed with random traffic.
  task automatic test_random_traffic(input int n_items);
    int sent;
    int kind;
    int len;
    int ins_pct;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 3);
      case (kind)
        0: begin
          len = QUEUE_DEPTH - held_count + $urandom_range(0, 2);
          ins_pct = 100;
        end
        1: begin
          len = held_count + $urandom_range(0, 2);
          ins_pct = 0;
        end
        2: begin
          len = $urandom_range(10, 40);
          ins_pct = 50;
        end
        default: begin
          len = $urandom_range(10, 30);
          ins_pct = 65;
        end
      endcase
      repeat (len) begin
        send_item(random_request(($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT
                                                                   : FUNC_REMOVE));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // A long stretch with neither side idling.
  task automatic test_no_idle();
    idle_pct  = 0;
    stall_pct = 0;
    test_random_traffic(150);
    idle_pct  = DEFAULT_IDLE_PCT;
    stall_pct = DEFAULT_IDLE_PCT;
  endtask

  // Receiver: random stalls, plus a counted hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    errors++;
  endtask

  // Compare each output transfer with the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_data.out_value !== want.out_value)
          report_field("out_value", want.out_value, out_data.out_value);
        if (out_data.out_priority !== want.out_priority)
          report_field("out_priority", 32'(want.out_priority), 32'(out_data.out_priority));
        if (out_data.status !== want.status)
          report_field("status", 32'(want.status), 32'(out_data.status));
        if (out_data.fill_count !== want.fill_count)
          report_field("fill_count", 32'(want.fill_count), 32'(out_data.fill_count));
        case (want.status)
          ST_FULL:  full_refusals++;
          ST_EMPTY: empty_refusals++;
          default: begin
          end
        endcase
      end
    end
  end

  // Tally operations as they are transferred in.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (in_data.func == FUNC_INSERT) inserts_done++;
      else removes_done++;
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    held_count = 0;
    peak_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_queue();
    test_backpressure();
    test_no_idle();
    test_random_traffic(820);

    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d results: %0d inserts (%0d refused on full), %0d removes",
             results_seen, inserts_done, full_refusals, removes_done);
    $display("(%0d on empty), peak fill %0d, with hold-off and no-idle stretches.",
             empty_refusals, peak_count);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/stable_priority_queue.sv
verif/stable_priority_queue_tb.sv
